@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the pixel write formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, also across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/pcwf_pkg.sv @@
// Package with types, codes and color conversion functions of the pixel write formatter.
`default_nettype none
package pcwf_pkg;

   localparam int unsigned CoordWidth  = 16;
   localparam int unsigned DimWidth    = 13;
   localparam int unsigned PitchWidth  = 15;
   localparam int unsigned BppWidth    = 6;
   localparam int unsigned ColourWidth = 32;
   localparam int unsigned OffsetWidth = 26;
   localparam int unsigned CountWidth  = 3;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = PitchWidth;
   localparam int unsigned ProductWidth = DimWidth + PitchWidth;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_DISPLAY_ENABLED = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SCREEN_WIDTH    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SCREEN_HEIGHT   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_ROW_PITCH_BYTES = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_BITS_PER_PIXEL  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_BACK_BUFFER_ON  = 3'd5;

   // Supported pixel depths.
   localparam logic [BppWidth-1:0] BPP_8  = 6'd8;
   localparam logic [BppWidth-1:0] BPP_16 = 6'd16;
   localparam logic [BppWidth-1:0] BPP_24 = 6'd24;
   localparam logic [BppWidth-1:0] BPP_32 = 6'd32;

   // Byte counts of a write.
   localparam logic [CountWidth-1:0] COUNT_1 = 3'd1;
   localparam logic [CountWidth-1:0] COUNT_2 = 3'd2;
   localparam logic [CountWidth-1:0] COUNT_3 = 3'd3;
   localparam logic [CountWidth-1:0] COUNT_4 = 3'd4;

   // Destination memories.
   localparam logic TARGET_FRAMEBUFFER = 1'b0;
   localparam logic TARGET_BACKBUFFER  = 1'b1;

   typedef struct packed {
      logic                  display_enabled;
      logic [DimWidth-1:0]   screen_width;
      logic [DimWidth-1:0]   screen_height;
      logic [PitchWidth-1:0] row_pitch_bytes;
      logic [BppWidth-1:0]   bits_per_pixel;
      logic                  back_buffer_on;
   } cfg_type;

   typedef struct packed {
      logic                   keep;
      logic                   target_buffer;
      logic [OffsetWidth-1:0] byte_offset;
      logic [ColourWidth-1:0] write_data;
      logic [CountWidth-1:0]  byte_count;
   } result_type;

   function automatic logic [15:0] to_rgb565(input logic [ColourWidth-1:0] c);
      to_rgb565 = {c[23:19], c[15:10], c[7:3]};
   endfunction

   // Scales one channel to 0..5: the channel times six, divided by 256.
   function automatic logic [2:0] level6(input logic [7:0] ch);
      logic [10:0] prod;
      prod   = {1'b0, ch, 2'b00} + {2'b00, ch, 1'b0};
      level6 = prod[10:8];
   endfunction

   function automatic logic [7:0] to_palette(input logic [ColourWidth-1:0] c);
      logic [2:0] ri;
      logic [2:0] gi;
      logic [2:0] bi;
      ri = level6(c[23:16]);
      gi = level6(c[15:8]);
      bi = level6(c[7:0]);
      to_palette = 8'd16 + ({5'd0, ri} * 8'd36) + ({5'd0, gi} * 8'd6) + {5'd0, bi};
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/clipped_pixel_write_formatter_core.sv @@
// An accepted request passes the input register, then the result register, to its write item on the response side.
// Throughput: one item per cycle while the response side does not stall, set by the single input and result registers.
// An item that is clipped or has an unsupported depth produces no write item.
// Synchronous active-high reset clears both valid flags and all configuration registers
// to zero, so the display starts disabled and every request is dropped until set up.
`default_nettype none
`include "assert_macros.svh"
module clipped_pixel_write_formatter_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic signed [pcwf_pkg::CoordWidth-1:0] req_pos_x,
   input  wire logic signed [pcwf_pkg::CoordWidth-1:0] req_pos_y,
   input  wire logic [pcwf_pkg::ColourWidth-1:0]      req_pixel_colour,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic                                  rsp_target_buffer,
   output      logic [pcwf_pkg::OffsetWidth-1:0]      rsp_byte_offset,
   output      logic [pcwf_pkg::ColourWidth-1:0]      rsp_write_data,
   output      logic [pcwf_pkg::CountWidth-1:0]       rsp_byte_count,
   input  wire logic                                  csr_write,
   input  wire logic [pcwf_pkg::CsrIdxWidth-1:0]      csr_index,
   input  wire logic [pcwf_pkg::CsrDataWidth-1:0]     csr_data
);

   pcwf_pkg::cfg_type    cfg;
   pcwf_pkg::result_type result;

   logic                                   s1_valid_ff;
   logic                                   s1_valid_in;
   logic signed [pcwf_pkg::CoordWidth-1:0] s1_x_ff;
   logic signed [pcwf_pkg::CoordWidth-1:0] s1_y_ff;
   logic [pcwf_pkg::ColourWidth-1:0]       s1_colour_ff;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   pcwf_pkg::result_type                   rsp_ff;
   logic                                   advance_out;
   logic                                   accept_in;

   pcwf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pcwf_format u_format (
      .cfg          (cfg),
      .pos_x        (s1_x_ff),
      .pos_y        (s1_y_ff),
      .pixel_colour (s1_colour_ff),
      .result       (result)
   );

   // The result register moves whenever it is empty or its item is being taken.
   assign advance_out  = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = s1_valid_ff && !advance_out;
   assign accept_in    = req_valid && !req_stall;
   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = advance_out ? (s1_valid_ff && result.keep) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         s1_x_ff      <= req_pos_x;
         s1_y_ff      <= req_pos_y;
         s1_colour_ff <= req_pixel_colour;
      end
      if (advance_out) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target_buffer = rsp_ff.target_buffer;
   assign rsp_byte_offset   = rsp_ff.byte_offset;
   assign rsp_write_data    = rsp_ff.write_data;
   assign rsp_byte_count    = rsp_ff.byte_count;

   `ASSERT_IMPLY(a_count_legal, clock, reset, rsp_valid_ff,
      (rsp_ff.byte_count == pcwf_pkg::COUNT_1) || (rsp_ff.byte_count == pcwf_pkg::COUNT_2) ||
      (rsp_ff.byte_count == pcwf_pkg::COUNT_3) || (rsp_ff.byte_count == pcwf_pkg::COUNT_4))
   `ASSERT_IMPLY(a_back_aligned, clock, reset,
      rsp_valid_ff && (rsp_ff.target_buffer == pcwf_pkg::TARGET_BACKBUFFER),
      (rsp_ff.byte_count == pcwf_pkg::COUNT_4) && (rsp_ff.byte_offset[1:0] == 2'b00))
   `ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall,
      s1_valid_ff && rsp_valid_ff && rsp_stall)
   `ASSERT_NEXT(a_drop_empty, clock, reset,
      advance_out && !(s1_valid_ff && result.keep), !rsp_valid_ff)
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !s1_valid_ff && !rsp_valid_ff)

endmodule
`default_nettype wire

@@ hw/rtl/pcwf_csr.sv @@
// Configuration register file of the pixel write formatter.
`default_nettype none
module pcwf_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [pcwf_pkg::CsrIdxWidth-1:0]      csr_index,
   input  wire logic [pcwf_pkg::CsrDataWidth-1:0]     csr_data,
   output pcwf_pkg::cfg_type                          cfg
);

   pcwf_pkg::cfg_type cfg_ff;
   pcwf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            pcwf_pkg::CSR_DISPLAY_ENABLED: cfg_in.display_enabled = csr_data[0];
            pcwf_pkg::CSR_SCREEN_WIDTH:
               cfg_in.screen_width = csr_data[pcwf_pkg::DimWidth-1:0];
            pcwf_pkg::CSR_SCREEN_HEIGHT:
               cfg_in.screen_height = csr_data[pcwf_pkg::DimWidth-1:0];
            pcwf_pkg::CSR_ROW_PITCH_BYTES:
               cfg_in.row_pitch_bytes = csr_data[pcwf_pkg::PitchWidth-1:0];
            pcwf_pkg::CSR_BITS_PER_PIXEL:
               cfg_in.bits_per_pixel = csr_data[pcwf_pkg::BppWidth-1:0];
            pcwf_pkg::CSR_BACK_BUFFER_ON: cfg_in.back_buffer_on = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ hw/rtl/pcwf_format.sv @@
// Clipping, address arithmetic and color formatting of one pixel item.
`default_nettype none
module pcwf_format (
   input  pcwf_pkg::cfg_type                            cfg,
   input  wire logic signed [pcwf_pkg::CoordWidth-1:0]  pos_x,
   input  wire logic signed [pcwf_pkg::CoordWidth-1:0]  pos_y,
   input  wire logic [pcwf_pkg::ColourWidth-1:0]        pixel_colour,
   output pcwf_pkg::result_type                         result
);

   logic                                  inside_x;
   logic                                  inside_y;
   logic [pcwf_pkg::DimWidth-1:0]         x_pix;
   logic [pcwf_pkg::DimWidth-1:0]         y_pix;
   logic [pcwf_pkg::PitchWidth-1:0]       stride;
   logic [pcwf_pkg::PitchWidth-1:0]       x_term;
   logic [pcwf_pkg::ProductWidth-1:0]     row_offset;
   logic                                  depth_ok;
   logic                                  use_back;
   logic                                  target_sel;
   logic [pcwf_pkg::ColourWidth-1:0]      data_sel;
   logic [pcwf_pkg::CountWidth-1:0]       count_sel;
   logic [pcwf_pkg::OffsetWidth-1:0]      offset_sum;
   logic                                  keep;

   // A negative coordinate has its sign bit set and fails the compare as unsigned.
   assign inside_x = ({1'b0, pos_x} < {4'd0, cfg.screen_width});
   assign inside_y = ({1'b0, pos_y} < {4'd0, cfg.screen_height});
   assign x_pix    = pos_x[pcwf_pkg::DimWidth-1:0];
   assign y_pix    = pos_y[pcwf_pkg::DimWidth-1:0];
   assign use_back = cfg.back_buffer_on && (cfg.bits_per_pixel == pcwf_pkg::BPP_32);

   always_comb begin
      depth_ok   = 1'b1;
      stride     = cfg.row_pitch_bytes;
      x_term     = {2'b00, x_pix};
      target_sel = pcwf_pkg::TARGET_FRAMEBUFFER;
      data_sel   = pixel_colour;
      count_sel  = pcwf_pkg::COUNT_4;
      if (use_back) begin
         target_sel = pcwf_pkg::TARGET_BACKBUFFER;
         stride     = {cfg.screen_width, 2'b00};
         x_term     = {x_pix, 2'b00};
      end else begin
         case (cfg.bits_per_pixel)
            pcwf_pkg::BPP_32: begin
               stride = {cfg.row_pitch_bytes[pcwf_pkg::PitchWidth-1:2], 2'b00};
               x_term = {x_pix, 2'b00};
            end
            pcwf_pkg::BPP_24: begin
               x_term    = {1'b0, x_pix, 1'b0} + {2'b00, x_pix};
               data_sel  = {8'd0, pixel_colour[23:0]};
               count_sel = pcwf_pkg::COUNT_3;
            end
            pcwf_pkg::BPP_16: begin
               stride    = {cfg.row_pitch_bytes[pcwf_pkg::PitchWidth-1:1], 1'b0};
               x_term    = {1'b0, x_pix, 1'b0};
               data_sel  = {16'd0, pcwf_pkg::to_rgb565(pixel_colour)};
               count_sel = pcwf_pkg::COUNT_2;
            end
            pcwf_pkg::BPP_8: begin
               data_sel  = {24'd0, pcwf_pkg::to_palette(pixel_colour)};
               count_sel = pcwf_pkg::COUNT_1;
            end
            default: depth_ok = 1'b0;
         endcase
      end
   end

   assign row_offset = {{pcwf_pkg::PitchWidth{1'b0}}, y_pix} *
                       {{pcwf_pkg::DimWidth{1'b0}}, stride};

   assign offset_sum = row_offset[pcwf_pkg::OffsetWidth-1:0] +
      {{(pcwf_pkg::OffsetWidth - pcwf_pkg::PitchWidth){1'b0}}, x_term};

   assign keep = cfg.display_enabled && inside_x && inside_y && depth_ok;

   assign result = {keep, target_sel, offset_sum, data_sel, count_sel};

endmodule
`default_nettype wire
